// File: design/wpg2rle_pkg.sv
// ----------------------------------------------------------------------------
// WPG2 run-length token decoder package
// Shared widths, token and result codes, and the divider request and response types.
// ----------------------------------------------------------------------------
package wpg2rle_pkg;

	localparam int MAX_SAMPLE_BYTES_DEF = 8;

	localparam int ROW_BYTES_W = 18;
	localparam int HEIGHT_W    = 16;
	localparam int COL_W       = 18;
	localparam int ROW_W       = 20;
	localparam int POS_W       = 19;
	localparam int CNT_W       = 9;
	localparam int NB_W        = 12;
	localparam int BREM_W      = 11;
	localparam int SIZE_W      = 4;
	localparam int VAL_W       = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 18;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [7:0] OP_DSZ   = 8'h7D;
	localparam logic [7:0] OP_XOR   = 8'h7E;
	localparam logic [7:0] OP_BLK   = 8'h7F;
	localparam logic [7:0] OP_EXT   = 8'hFD;
	localparam logic [7:0] OP_RST   = 8'hFE;
	localparam logic [7:0] OP_WHT   = 8'hFF;
	localparam logic [7:0] OP_REP_F = 8'h80;

	localparam logic [1:0] KIND_LITERAL = 2'd0;
	localparam logic [1:0] KIND_FILL    = 2'd1;
	localparam logic [1:0] KIND_ROWREP  = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_SIZE     = 2'd1;
	localparam logic [1:0] ERR_ALIGN    = 2'd2;
	localparam logic [1:0] ERR_PAST_END = 2'd3;

	typedef struct packed {
		logic                   valid;
		logic [POS_W-1:0]       dividend;
		logic [ROW_BYTES_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                   done;
		logic [POS_W-1:0]       quotient;
		logic [ROW_BYTES_W-1:0] remainder;
	} div_rsp_t;

endpackage

// File: design/wpg2rle_div.sv
// ----------------------------------------------------------------------------
// WPG2 run-length position divider
// Restoring divider, one quotient bit per cycle, splits a byte position into
// a row advance and a column.
// ----------------------------------------------------------------------------
module wpg2rle_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wpg2rle_pkg::div_req_t req,
	output wpg2rle_pkg::div_rsp_t rsp
);

	localparam int POS_W = wpg2rle_pkg::POS_W;
	localparam int RB_W  = wpg2rle_pkg::ROW_BYTES_W;
	localparam int CNT_W = $clog2(POS_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [POS_W-1:0] quo_q;
	logic [RB_W-1:0]  rem_q;
	logic [RB_W-1:0]  dvs_q;

	logic [RB_W:0]    rem_sh;
	logic [RB_W+1:0]  diff;
	logic             qbit;

	always_comb begin
		rem_sh = {rem_q, quo_q[POS_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
		qbit   = !diff[RB_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.valid && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(POS_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && !busy_q) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[POS_W-2:0], qbit};
			rem_q <= qbit ? diff[RB_W-1:0] : rem_sh[RB_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> !busy_q)
		else $error("Divider started while busy.");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < dvs_q))
		else $error("Divider remainder not below divisor.");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q))
		else $error("Divider finished without running.");

endmodule

// File: design/wpg2_rle_token_decoder_core.sv
// ----------------------------------------------------------------------------
// WPG2 run-length token decoder core
// Parses one byte of a WPG level-2 run-length raster stream per request and
// emits run descriptors for literal bytes, sample fills and row repeats.
//
// The input channel takes one stream byte per request, with start_of_image
// clearing the position, sample size and parse state before that byte. The
// output channel carries one descriptor or error per finished token. Both use
// valid and stall; in_stall is high while a byte is being worked on.
// A byte that only advances the parser leaves the core idle. For a byte that
// ends a fill or a literal, the new column and row come from a restoring
// divider that produces one quotient bit per cycle; the core waits in its
// divide state and then registers the result. Errors and row repeats go
// straight to the result state, where the result is registered.
// A finished result waits in the output register while the next byte is
// taken; when the receiver stalls with a result waiting, the core holds the
// next result and stalls its input. Reset clears the parse state, the sample
// store, the position and output valid, and sets both registers to one.
// ----------------------------------------------------------------------------
module wpg2_rle_token_decoder_core #(
	parameter int MAX_SAMPLE_BYTES = wpg2rle_pkg::MAX_SAMPLE_BYTES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [wpg2rle_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wpg2rle_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [7:0]                           stream_byte,
	input  logic                                 start_of_image,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           result_kind,
	output logic [wpg2rle_pkg::VAL_W-1:0]        sample_value,
	output logic [wpg2rle_pkg::SIZE_W-1:0]       sample_bytes,
	output logic [wpg2rle_pkg::CNT_W-1:0]        repeat_count,
	output logic [wpg2rle_pkg::COL_W-1:0]        start_column,
	output logic [wpg2rle_pkg::HEIGHT_W-1:0]     start_row,
	output logic [1:0]                           error_code,
	output logic                                 image_done
);

	localparam int RB_W   = wpg2rle_pkg::ROW_BYTES_W;
	localparam int HT_W   = wpg2rle_pkg::HEIGHT_W;
	localparam int COL_W  = wpg2rle_pkg::COL_W;
	localparam int ROW_W  = wpg2rle_pkg::ROW_W;
	localparam int POS_W  = wpg2rle_pkg::POS_W;
	localparam int CNT_W  = wpg2rle_pkg::CNT_W;
	localparam int NB_W   = wpg2rle_pkg::NB_W;
	localparam int BREM_W = wpg2rle_pkg::BREM_W;
	localparam int SIZE_W = wpg2rle_pkg::SIZE_W;
	localparam int VAL_W  = wpg2rle_pkg::VAL_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	localparam logic [2:0] PH_OPCODE  = 3'd0;
	localparam logic [2:0] PH_SIZE    = 3'd1;
	localparam logic [2:0] PH_COUNT   = 3'd2;
	localparam logic [2:0] PH_SAMPLE  = 3'd3;
	localparam logic [2:0] PH_LITERAL = 3'd4;

	logic [RB_W-1:0]   row_bytes_q;
	logic [HT_W-1:0]   height_q;

	logic [1:0]        state_q, nxt_state;
	logic [2:0]        phase_q, nxt_phase;
	logic [7:0]        opcode_q, nxt_opcode;
	logic [SIZE_W-1:0] size_q, nxt_size;
	logic [BREM_W-1:0] brem_q, nxt_brem;
	logic [COL_W-1:0]  col_q, nxt_col;
	logic [ROW_W-1:0]  row_q, nxt_row;
	logic              fin_q, nxt_fin;
	logic [7:0]        store_q [MAX_SAMPLE_BYTES];

	logic [1:0]        pkind_q, nxt_pkind;
	logic [VAL_W-1:0]  pval_q, nxt_pval;
	logic [SIZE_W-1:0] psize_q, nxt_psize;
	logic [CNT_W-1:0]  pcnt_q, nxt_pcnt;
	logic [COL_W-1:0]  pcol_q, nxt_pcol;
	logic [HT_W-1:0]   prow_q, nxt_prow;
	logic [1:0]        perr_q, nxt_perr;

	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [VAL_W-1:0]  value_q;
	logic [SIZE_W-1:0] sbytes_q;
	logic [CNT_W-1:0]  count_q;
	logic [COL_W-1:0]  scol_q;
	logic [HT_W-1:0]   srow_q;
	logic [1:0]        err_q;
	logic              done_q;

	logic              accept;
	logic              st_we;
	logic [SIZE_W-1:0] st_idx;
	logic              out_load;

	logic              e_done;
	logic [CNT_W-1:0]  count;
	logic [SIZE_W-1:0] e_size;
	logic [COL_W-1:0]  e_col;
	logic [ROW_W-1:0]  e_row;
	logic [VAL_W-1:0]  stored_val;
	logic [VAL_W-1:0]  white_val;
	logic [NB_W-1:0]   fill_bytes;
	logic [BREM_W-1:0] lit_len;
	logic [BREM_W-1:0] brem_dec;
	logic [RB_W-1:0]   divisor;

	wpg2rle_pkg::div_req_t div_req;
	wpg2rle_pkg::div_rsp_t div_rsp;

	wpg2rle_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept   = (state_q == S_IDLE) && in_valid;
	assign in_stall = (state_q != S_IDLE);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign divisor  = (row_bytes_q == '0) ? RB_W'(1) : row_bytes_q;

	always_comb begin
		e_size     = start_of_image ? SIZE_W'(1) : size_q;
		e_col      = start_of_image ? '0 : col_q;
		e_row      = start_of_image ? '0 : row_q;
		count      = CNT_W'(stream_byte) + CNT_W'(1);
		brem_dec   = (start_of_image || brem_q == '0) ? '0 : brem_q - BREM_W'(1);
		st_idx     = e_size - SIZE_W'(brem_q);
		st_we      = 1'b0;
		lit_len    = BREM_W'(e_size) * (BREM_W'(stream_byte[6:0]) + BREM_W'(1));
		stored_val = '0;
		white_val  = '0;
		for (int i = 0; i < MAX_SAMPLE_BYTES; i++) begin
			if (SIZE_W'(i) < e_size) begin
				stored_val[8*i +: 8] = store_q[i];
			end
		end
		for (int i = 0; i < 8; i++) begin
			if (SIZE_W'(i) < e_size) begin
				white_val[8*i +: 8] = 8'hFF;
			end
		end
		e_done = (start_of_image ? 1'b0 : fin_q) || (e_row >= ROW_W'(height_q));

		nxt_state  = state_q;
		nxt_phase  = phase_q;
		nxt_opcode = opcode_q;
		nxt_size   = size_q;
		nxt_brem   = brem_q;
		nxt_col    = col_q;
		nxt_row    = row_q;
		nxt_fin    = fin_q;
		nxt_pkind  = pkind_q;
		nxt_pval   = pval_q;
		nxt_psize  = psize_q;
		nxt_pcnt   = pcnt_q;
		nxt_pcol   = pcol_q;
		nxt_prow   = prow_q;
		nxt_perr   = perr_q;
		fill_bytes = '0;
		div_req    = '0;

		if (accept) begin
			if (start_of_image) begin
				nxt_phase  = PH_OPCODE;
				nxt_opcode = '0;
				nxt_size   = SIZE_W'(1);
				nxt_brem   = '0;
				nxt_col    = '0;
				nxt_row    = '0;
				nxt_fin    = 1'b0;
			end
			if (!e_done) begin
				nxt_pval  = '0;
				nxt_psize = SIZE_W'(1);
				nxt_pcnt  = CNT_W'(1);
				nxt_pcol  = e_col;
				nxt_prow  = e_row[HT_W-1:0];
				nxt_perr  = wpg2rle_pkg::ERR_NONE;
				case (start_of_image ? PH_OPCODE : phase_q)
					PH_OPCODE: begin
						nxt_opcode = stream_byte;
						if (stream_byte == wpg2rle_pkg::OP_DSZ) begin
							nxt_phase = PH_SIZE;
						end else if (stream_byte == wpg2rle_pkg::OP_XOR) begin
							nxt_phase = PH_OPCODE;
						end else if (stream_byte == wpg2rle_pkg::OP_BLK ||
							stream_byte == wpg2rle_pkg::OP_EXT ||
							stream_byte == wpg2rle_pkg::OP_RST ||
							stream_byte == wpg2rle_pkg::OP_WHT) begin
							nxt_phase = PH_COUNT;
						end else if ((stream_byte & wpg2rle_pkg::OP_REP_F) != '0) begin
							nxt_phase = PH_SAMPLE;
							nxt_brem  = BREM_W'(e_size);
						end else begin
							nxt_phase = PH_LITERAL;
							nxt_brem  = lit_len;
						end
					end
					PH_SIZE: begin
						nxt_phase = PH_OPCODE;
						if (stream_byte < 8'd1 || stream_byte > 8'(MAX_SAMPLE_BYTES)) begin
							nxt_fin   = 1'b1;
							nxt_pkind = wpg2rle_pkg::KIND_ERROR;
							nxt_perr  = wpg2rle_pkg::ERR_SIZE;
							nxt_state = S_OUT;
						end else begin
							nxt_size = stream_byte[SIZE_W-1:0];
						end
					end
					PH_COUNT: begin
						nxt_phase = PH_OPCODE;
						if (opcode_q == wpg2rle_pkg::OP_RST) begin
							nxt_pcnt  = count;
							nxt_state = S_OUT;
							if (e_col != '0) begin
								nxt_fin   = 1'b1;
								nxt_pkind = wpg2rle_pkg::KIND_ERROR;
								nxt_perr  = wpg2rle_pkg::ERR_ALIGN;
								nxt_pcnt  = CNT_W'(1);
							end else if (e_row + ROW_W'(count) > ROW_W'(height_q)) begin
								nxt_fin   = 1'b1;
								nxt_pkind = wpg2rle_pkg::KIND_ERROR;
								nxt_perr  = wpg2rle_pkg::ERR_PAST_END;
								nxt_pcnt  = CNT_W'(1);
							end else begin
								nxt_pkind = wpg2rle_pkg::KIND_ROWREP;
								nxt_row   = e_row + ROW_W'(count);
							end
						end else begin
							nxt_pkind  = wpg2rle_pkg::KIND_FILL;
							nxt_psize  = e_size;
							nxt_pcnt   = count;
							fill_bytes = NB_W'(e_size) * NB_W'(count);
							nxt_state  = S_DIV;
							if (opcode_q == wpg2rle_pkg::OP_WHT) begin
								nxt_pval = white_val;
							end else if (opcode_q == wpg2rle_pkg::OP_EXT) begin
								nxt_pval = stored_val;
							end
						end
					end
					PH_SAMPLE: begin
						st_we    = (st_idx < SIZE_W'(MAX_SAMPLE_BYTES));
						nxt_brem = brem_dec;
						if (brem_dec == '0) begin
							nxt_phase = PH_OPCODE;
							nxt_pkind = wpg2rle_pkg::KIND_FILL;
							nxt_psize = e_size;
							nxt_pcnt  = CNT_W'(opcode_q[6:0]) + CNT_W'(1);
							fill_bytes = NB_W'(e_size) *
								(NB_W'(opcode_q[6:0]) + NB_W'(1));
							nxt_state = S_DIV;
							nxt_pval  = stored_val;
							for (int i = 0; i < MAX_SAMPLE_BYTES; i++) begin
								if (st_we && st_idx == SIZE_W'(i)) begin
									nxt_pval[8*i +: 8] = stream_byte;
								end
							end
						end
					end
					PH_LITERAL: begin
						nxt_brem   = brem_dec;
						nxt_phase  = (brem_dec == '0) ? PH_OPCODE : PH_LITERAL;
						nxt_pkind  = wpg2rle_pkg::KIND_LITERAL;
						nxt_pval   = VAL_W'(stream_byte);
						fill_bytes = NB_W'(1);
						nxt_state  = S_DIV;
					end
					default: begin
						nxt_phase = PH_OPCODE;
					end
				endcase
				if (nxt_state == S_DIV) begin
					div_req.valid    = 1'b1;
					div_req.dividend = POS_W'(e_col) + POS_W'(fill_bytes);
					div_req.divisor  = divisor;
				end
			end
		end else if (state_q == S_DIV) begin
			if (div_rsp.done) begin
				nxt_row   = row_q + ROW_W'(div_rsp.quotient);
				nxt_col   = COL_W'(div_rsp.remainder);
				nxt_state = S_OUT;
			end
		end else if (out_load) begin
			nxt_state = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= RB_W'(1);
			height_q    <= HT_W'(1);
			state_q     <= S_IDLE;
			phase_q     <= PH_OPCODE;
			opcode_q    <= '0;
			size_q      <= SIZE_W'(1);
			brem_q      <= '0;
			col_q       <= '0;
			row_q       <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_SAMPLE_BYTES; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en && cfg_index == wpg2rle_pkg::REG_ROW_BYTES) begin
				row_bytes_q <= cfg_data[RB_W-1:0];
			end
			if (cfg_wr_en && cfg_index == wpg2rle_pkg::REG_IMAGE_HEIGHT) begin
				height_q <= cfg_data[HT_W-1:0];
			end
			state_q  <= nxt_state;
			phase_q  <= nxt_phase;
			opcode_q <= nxt_opcode;
			size_q   <= nxt_size;
			brem_q   <= nxt_brem;
			col_q    <= nxt_col;
			row_q    <= nxt_row;
			fin_q    <= nxt_fin;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			for (int i = 0; i < MAX_SAMPLE_BYTES; i++) begin
				if (accept && st_we && st_idx == SIZE_W'(i)) begin
					store_q[i] <= stream_byte;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pkind_q <= nxt_pkind;
		pval_q  <= nxt_pval;
		psize_q <= nxt_psize;
		pcnt_q  <= nxt_pcnt;
		pcol_q  <= nxt_pcol;
		prow_q  <= nxt_prow;
		perr_q  <= nxt_perr;
		if (out_load) begin
			kind_q   <= pkind_q;
			value_q  <= pval_q;
			sbytes_q <= psize_q;
			count_q  <= pcnt_q;
			scol_q   <= pcol_q;
			srow_q   <= prow_q;
			err_q    <= perr_q;
			done_q   <= fin_q || (row_q >= ROW_W'(height_q));
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign sample_value = value_q;
	assign sample_bytes = sbytes_q;
	assign repeat_count = count_q;
	assign start_column = scol_q;
	assign start_row    = srow_q;
	assign error_code   = err_q;
	assign image_done   = done_q;

	a_div_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_rsp.done) |=> (state_q == S_OUT))
		else $error("Position update did not lead to a result.");

	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("Result registered outside the result state.");

	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		(size_q >= SIZE_W'(1)) && (size_q <= SIZE_W'(MAX_SAMPLE_BYTES)))
		else $error("Sample size out of range.");

	a_error_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && pkind_q == wpg2rle_pkg::KIND_ERROR) |-> fin_q)
		else $error("Error result without finishing the image.");

endmodule
